// ----- rtl/fern_pkg.sv -----
// shared types and constants for the fern point plotter
package fern_pkg;

  localparam int FRAC = 16;

  // coefficients, hundredths rounded to 2^-16
  localparam logic signed [17:0] C_016 = 18'sd10486;
  localparam logic signed [17:0] C_015 = -18'sd9830;
  localparam logic signed [17:0] C_028 = 18'sd18350;
  localparam logic signed [17:0] C_026 = 18'sd17039;
  localparam logic signed [17:0] C_024 = 18'sd15729;
  localparam logic signed [17:0] C_020 = 18'sd13107;
  localparam logic signed [17:0] C_N26 = -18'sd17039;
  localparam logic signed [17:0] C_023 = 18'sd15073;
  localparam logic signed [17:0] C_022 = 18'sd14418;
  localparam logic signed [17:0] C_085 = 18'sd55706;
  localparam logic signed [17:0] C_004 = 18'sd2621;
  localparam logic signed [17:0] C_N04 = -18'sd2621;
  localparam logic signed [17:0] C_ZERO = 18'sd0;
  localparam logic signed [31:0] OFF_044 = 32'sd28836;
  localparam logic signed [31:0] OFF_160 = 32'sd104858;
  localparam logic signed [31:0] OFF_16 = 32'sd1048576;

  localparam logic [2:0] REG_ZOOM = 3'd0;
  localparam logic [2:0] REG_CX = 3'd1;
  localparam logic [2:0] REG_CY = 3'd2;
  localparam logic [2:0] REG_OX = 3'd3;
  localparam logic [2:0] REG_OY = 3'd4;
  localparam logic [2:0] REG_MODE = 3'd5;
  localparam logic [2:0] REG_RUN = 3'd6;

  localparam logic [1:0] MODE_GREEN = 2'd0;
  localparam logic [1:0] MODE_GRAY = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAP, ST_PIX, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic map;
    logic pix;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

// ----- rtl/fern_ctrl.sv -----
// controller state machine for the fern point plotter
module fern_ctrl import fern_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MAP;
      ST_MAP:  state_next = ST_PIX;
      ST_PIX:  state_next = ST_DIV;
      ST_DIV:  if (stat.div_done) state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MAP: cmd.map = 1'b1;
      ST_PIX: cmd.pix = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.finish = out_ready;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/fern_datapath.sv -----
// point update, pixel mapping and color datapath
module fern_datapath import fern_pkg::*; #(
  parameter int IMAGE_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [6:0]  dice,
  input  logic        start_req,
  input  logic [23:0] zoom,
  input  logic [11:0] center_x,
  input  logic [11:0] center_y,
  input  logic [31:0] offset_x,
  input  logic [31:0] offset_y,
  input  logic [1:0]  paint_mode,
  input  logic [23:0] run_length,
  output logic [19:0] pixel_address,
  output logic        pixel_write,
  output logic [23:0] pixel_color,
  output logic        run_last
);

  logic signed [31:0] point_x, point_y, nx, ny;
  logic [23:0] remaining_count, cnt, len;
  logic [6:0]  dice_q;
  logic signed [17:0] cxx, cxy, cyx, cyy;
  logic signed [31:0] offy;
  logic signed [50:0] sx, sy;
  logic signed [34:0] fx, fy;
  logic signed [31:0] px_pt, py_pt;
  logic signed [33:0] d2x, d2y;
  logic signed [58:0] tx, ty, qx, qy;
  logic signed [63:0] ax, ay;
  logic signed [58:0] vx, vy;
  logic        on_image;
  logic [19:0] addr;
  // restoring divider for 255*count/len
  logic [31:0] num;
  logic [24:0] rem;
  logic [5:0]  dcnt;
  logic [25:0] trial;
  logic [7:0]  green;

  assign len = (run_length == 24'd0) ? 24'd1 : run_length;

  always_comb begin
    unique case (1'b1)
      (dice_q == 7'd0): begin
        cxx = C_ZERO; cxy = C_ZERO; cyx = C_ZERO; cyy = C_016; offy = '0;
      end
      (dice_q != 7'd0 && dice_q < 7'd8): begin
        cxx = C_015; cxy = C_028; cyx = C_026; cyy = C_024; offy = OFF_044;
      end
      (dice_q >= 7'd8 && dice_q < 7'd16): begin
        cxx = C_020; cxy = C_N26; cyx = C_023; cyy = C_022; offy = OFF_160;
      end
      default: begin
        cxx = C_085; cxy = C_004; cyx = C_N04; cyy = C_085; offy = OFF_16;
      end
    endcase
  end

  assign sx = 51'(cxx) * 51'(point_x) + 51'(cxy) * 51'(point_y);
  assign sy = 51'(cyx) * 51'(point_x) + 51'(cyy) * 51'(point_y);
  assign fx = 35'(sx >>> FRAC);
  assign fy = 35'(sy >>> FRAC) + 35'(offy);

  function automatic logic signed [31:0] sat(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign d2x = {px_pt[31], px_pt, 1'b0} - 34'(signed'(offset_x));
  assign d2y = {py_pt[31], py_pt, 1'b0} - 34'(signed'(offset_y));
  assign tx = 59'(d2x) * 59'(signed'({1'b0, zoom}));
  assign ty = 59'(d2y) * 59'(signed'({1'b0, zoom}));

  assign ax = {{19{center_x[11]}}, center_x, 33'd0} + 64'(qx);
  assign ay = {{19{center_y[11]}}, center_y, 33'd0} + 64'(qy);

  always_comb begin
    logic [63:0] absx, absy;
    absx = ax[63] ? -ax : ax;
    absy = ay[63] ? -ay : ay;
    vx = 59'(ax[63] ? -(absx >> 33) : (absx >> 33));
    vy = 59'(ay[63] ? -(absy >> 33) : (absy >> 33));
  end

  assign on_image = (vx >= 0) && (vx < IMAGE_SIDE) && (vy >= 0) && (vy < IMAGE_SIDE);
  assign addr = vx[19:0] + vy[19:0] * 20'(IMAGE_SIDE);
  assign trial = {rem, num[31]} - {2'b0, len};

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
      remaining_count <= '0;
      dcnt <= '0;
    end else begin
      if (cmd.load) begin
        dice_q <= dice;
        if (start_req || remaining_count == 24'd0) begin
          point_x <= '0;
          point_y <= '0;
          cnt <= len;
        end else begin
          cnt <= remaining_count;
        end
      end
      if (cmd.map) begin
        nx <= (dice_q == 7'd0) ? 32'sd0 : sat(fx);
        ny <= sat(fy);
        px_pt <= (dice_q == 7'd0) ? 32'sd0 : sat(fx);
        py_pt <= sat(fy);
      end
      if (cmd.pix) begin
        qx <= tx;
        qy <= ty;
        num <= {cnt, 8'd0} - 32'(cnt);
        rem <= '0;
        dcnt <= 6'd32;
      end
      if (cmd.div_step && dcnt != 6'd0) begin
        if (!trial[25]) begin
          rem <= trial[24:0];
          num <= {num[30:0], 1'b1};
        end else begin
          rem <= {rem[23:0], num[31]};
          num <= {num[30:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
      end
      if (cmd.finish) begin
        point_x <= nx;
        point_y <= ny;
        remaining_count <= cnt - 24'd1;
      end
    end
  end

  assign stat.div_done = (dcnt == 6'd0);
  assign green = (num > 32'd255) ? 8'hff : num[7:0];

  always_comb begin
    logic [7:0] gray;
    gray = 8'(dice_q * 8'd255);
    pixel_write = on_image;
    pixel_address = on_image ? addr : '0;
    run_last = (cnt == 24'd1);
    if (!on_image) pixel_color = '0;
    else if (paint_mode == MODE_GREEN) pixel_color = {8'd0, green, 8'd0};
    else if (paint_mode == MODE_GRAY) pixel_color = {gray, gray, gray};
    else pixel_color = '0;
  end

endmodule

// ----- rtl/fern_ifs_point_plotter_core.sv -----
// fern point plotter top level
// one item at a time: accept, map, pixel scale, then a 32 step divide for the green ramp
// result valid after the divide, held until taken; the next input is accepted only
// once the result is taken; the restoring divider (one quotient bit a cycle) sets the rate
// synchronous active high reset clears the point and the run count,
// config registers return to their reset values
module fern_ifs_point_plotter_core import fern_pkg::*; #(
  parameter int IMAGE_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // dice[6:0]
  input  logic        s_axis_tuser,   // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pixel_address, pixel_write, pixel_color
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [23:0] zoom, run_length;
  logic [11:0] center_x, center_y;
  logic [31:0] offset_x, offset_y;
  logic [1:0]  paint_mode;
  cmd_t        cmd;
  stat_t       stat;
  logic [19:0] pixel_address;
  logic        pixel_write;
  logic [23:0] pixel_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom <= 24'd589824;
      center_x <= 12'd512;
      center_y <= 12'd50;
      offset_x <= '0;
      offset_y <= '0;
      paint_mode <= '0;
      run_length <= 24'd1500000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ZOOM: zoom <= cfg_data[23:0];
        REG_CX:   center_x <= cfg_data[11:0];
        REG_CY:   center_y <= cfg_data[11:0];
        REG_OX:   offset_x <= cfg_data;
        REG_OY:   offset_y <= cfg_data;
        REG_MODE: paint_mode <= cfg_data[1:0];
        REG_RUN:  run_length <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  fern_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat, .cmd
  );

  fern_datapath #(.IMAGE_SIDE(IMAGE_SIDE)) u_dp (
    .clk, .rst, .cmd, .stat,
    .dice(s_axis_tdata[6:0]), .start_req(s_axis_tuser),
    .zoom, .center_x, .center_y, .offset_x, .offset_y, .paint_mode, .run_length,
    .pixel_address, .pixel_write, .pixel_color, .run_last(m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, pixel_color, pixel_write, pixel_address};

  a_no_write_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[20] |-> m_axis_tdata[19:0] == 20'd0)
    else $error("address set without write");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output both open");
  a_dark_outside: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[20] |-> m_axis_tdata[44:21] == 24'd0)
    else $error("color set outside image");

endmodule
